// ===== hw/rtl/dsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dsg_pkg;

  // Storage layout: text characters first, header bytes behind them.
  localparam int unsigned MemDepth = 59;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  typedef logic [AddrW-1:0] addr_t;

  localparam addr_t      HdrBase   = addr_t'(20);
  localparam logic [5:0] TextLen   = 6'd20;
  localparam logic [5:0] HdrLen    = 6'd39;
  localparam logic [3:0] TextSlots = 4'd8;
  localparam logic [4:0] HdrSlots  = 5'd17;

  localparam logic [7:0] Scr0        = 8'h70;
  localparam logic [7:0] Scr1        = 8'h4F;
  localparam logic [7:0] Scr2        = 8'h93;
  localparam logic [7:0] FillByte    = 8'h66;
  localparam logic [7:0] HdrFlag     = 8'h40;
  localparam logic [7:0] TextSegMark = 8'h40;
  localparam logic [7:0] HdrMark     = 8'h55;
  localparam logic [7:0] HdrTailMark = 8'h51;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h8408;

  typedef enum logic [2:0] {
    ACT_WR_TEXT  = 3'd0,
    ACT_WR_HDR   = 3'd1,
    ACT_BEG_TEXT = 3'd2,
    ACT_BEG_HDR  = 3'd3,
    ACT_REWIND   = 3'd4,
    ACT_GET      = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_GET,
    ST_LAST,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] index;
    logic [7:0] value;
    logic       finish;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic       is_filler;
  } out_t;

  typedef struct packed {
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
    logic       re;
    addr_t      raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dstar_slow_data_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake             | Beat payload
// in      | input     | in_valid_i/in_stall_o  | action, index, value, finish
// out     | output    | out_valid_o/out_stall_i| three scrambled bytes, filler flag
//
// Writes, begin and rewind beats are carried out in the cycle that accepts them.
// A get beat on an active stream steps through the slot bytes in ST_GET, reading stored
// bytes from memory and taking marks and CRC bytes as constants, then passes ST_LAST and
// loads the output in ST_OUT; a filler get goes straight to ST_OUT. Arming the header
// runs the one-byte-per-cycle CRC walk over the 39 stored header bytes through the single
// memory read port. Reset clears the FSM, mode, slot and walk-counter state, not the memory.
// A stalled output holds the finished beat and only blocks the next get at its last step.
module dstar_slow_data_generator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dsg_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dsg_pkg::out_t      out_data_o
);
  import dsg_pkg::*;

  // A read issued in one cycle is resolved in the next, when its data is out of
  // the memory. Constant bytes travel along the same pipe.
  typedef struct packed {
    logic       valid;
    logic       from_mem;
    logic [7:0] data;
    logic [1:0] k;
  } pend_t;

  typedef struct packed {
    logic       from_mem;
    logic [7:0] data;
    addr_t      addr;
  } src_t;

  state_e      state_q, state_d;
  logic        mode_q, mode_d;            // 1 = header mode
  logic        armed_q, armed_d;
  logic [3:0]  tslot_q, tslot_d;
  logic [4:0]  hslot_q, hslot_d;
  logic [5:0]  cnt_q, cnt_d;              // CRC walk position
  logic [15:0] crc_q, crc_d;              // finished header CRC
  logic [15:0] crc_work_q, crc_work_d;
  logic        gmode_q, gmode_d;
  logic [4:0]  gslot_q, gslot_d;
  logic [1:0]  k_q, k_d;
  pend_t       pend_q, pend_d;
  logic [7:0]  buf_q [3];
  logic [7:0]  buf_d [3];
  logic        filler_q, filler_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  mem_req_t    mem_req;
  logic [7:0]  rdata;
  logic        in_accept;
  src_t        src;
  logic [15:0] crc_next;

  function automatic logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  dsg_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Where byte k of the current slot comes from. A slot is half of a six-byte
  // group, so the group is the slot over two and the odd slot starts at offset 3.
  always_comb begin
    logic [2:0] off;
    logic [3:0] grp;
    logic [5:0] lin;
    off = (gslot_q[0] ? 3'd3 : 3'd0) + {1'b0, k_q};
    grp = gslot_q[4:1];
    lin = {grp, 2'b00} + {2'b00, grp} + {3'b000, off} - 6'd1;
    src = '{from_mem: 1'b0, data: FillByte, addr: '0};
    if (!gmode_q) begin
      if (off == 3'd0) begin
        src.data = TextSegMark + {4'h0, grp};
      end else begin
        src.from_mem = 1'b1;
        src.addr     = addr_t'(lin);
      end
    end else if (gslot_q == HdrSlots - 5'd1) begin
      // The tail slot: tail mark, CRC high byte, then a filler byte.
      case (k_q)
        2'd0:    src.data = HdrTailMark;
        2'd1:    src.data = crc_q[15:8];
        default: src.data = FillByte;
      endcase
    end else if (off == 3'd0) begin
      src.data = HdrMark;
    end else if (lin < HdrLen) begin
      src.from_mem = 1'b1;
      src.addr     = HdrBase + addr_t'(lin);
    end else begin
      src.data = crc_q[7:0];
    end
  end

  assign crc_next = crc_fold(crc_work_q, (cnt_q == 6'd1) ? HdrFlag : rdata);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    armed_d     = armed_q;
    tslot_d     = tslot_q;
    hslot_d     = hslot_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    crc_work_d  = crc_work_q;
    gmode_d     = gmode_q;
    gslot_d     = gslot_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_d.valid = 1'b0;
    buf_d       = buf_q;
    filler_d    = filler_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_req     = '{we: 1'b0, waddr: '0, wdata: in_data_i.value, re: 1'b0, raddr: '0};

    if (pend_q.valid) begin
      buf_d[pend_q.k] = pend_q.from_mem ? rdata : pend_q.data;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data_i.action)
            ACT_WR_TEXT: begin
              if (in_data_i.index < TextLen) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = addr_t'(in_data_i.index);
              end
              if (in_data_i.finish) begin
                tslot_d = '0;
              end
            end
            ACT_WR_HDR: begin
              if (in_data_i.index < HdrLen) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = HdrBase + addr_t'(in_data_i.index);
              end
              if (in_data_i.finish) begin
                cnt_d      = '0;
                crc_work_d = CrcInit;
                state_d    = ST_WALK;
              end
            end
            ACT_BEG_TEXT: begin
              mode_d  = 1'b0;
              tslot_d = '0;
            end
            ACT_BEG_HDR: begin
              mode_d  = 1'b1;
              hslot_d = '0;
            end
            ACT_REWIND: begin
              if (mode_q) begin
                hslot_d = '0;
              end else begin
                tslot_d = '0;
              end
            end
            ACT_GET: begin
              k_d      = '0;
              filler_d = 1'b0;
              if (!mode_q && tslot_q < TextSlots) begin
                gmode_d = 1'b0;
                gslot_d = {1'b0, tslot_q};
                tslot_d = tslot_q + 4'd1;
                state_d = ST_GET;
              end else if (mode_q && armed_q && hslot_q < HdrSlots) begin
                gmode_d = 1'b1;
                gslot_d = hslot_q;
                hslot_d = hslot_q + 5'd1;
                state_d = ST_GET;
              end else begin
                buf_d    = '{FillByte, FillByte, FillByte};
                filler_d = 1'b1;
                state_d  = ST_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // The first cycle forces the flag byte into storage; the walk itself
        // folds the flag constant for byte 0, so the same-cycle read is harmless.
        if (cnt_q == 6'd0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = HdrBase;
          mem_req.wdata = HdrFlag;
        end
        if (cnt_q < HdrLen) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = HdrBase + addr_t'(cnt_q);
          cnt_d         = cnt_q + 6'd1;
        end
        if (cnt_q != 6'd0) begin
          crc_work_d = crc_next;
        end
        if (cnt_q == HdrLen) begin
          crc_d   = ~crc_next;
          armed_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_GET: begin
        mem_req.re    = src.from_mem;
        mem_req.raddr = src.addr;
        pend_d        = '{valid: 1'b1, from_mem: src.from_mem, data: src.data, k: k_q};
        k_d           = k_q + 2'd1;
        if (k_q == 2'd2) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d = '{byte_first:  buf_q[0] ^ Scr0,
                    byte_second: buf_q[1] ^ Scr1,
                    byte_third:  buf_q[2] ^ Scr2,
                    is_filler:   filler_q};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      armed_q     <= 1'b0;
      tslot_q     <= TextSlots;
      hslot_q     <= HdrSlots;
      cnt_q       <= '0;
      crc_q       <= '0;
      k_q         <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      armed_q     <= armed_d;
      tslot_q     <= tslot_d;
      hslot_q     <= hslot_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_work_q <= crc_work_d;
    gmode_q    <= gmode_d;
    gslot_q    <= gslot_d;
    buf_q      <= buf_d;
    filler_q   <= filler_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The header only becomes valid at the end of a CRC walk.
  a_arm_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(armed_q) |-> $past(state_q == ST_WALK))
    else $error("header armed outside the CRC walk");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= HdrLen)
    else $error("CRC walk ran past the header");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tslot_q <= TextSlots && hslot_q <= HdrSlots)
    else $error("slot counter beyond its exhausted value");

  a_read_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |-> (state_q == ST_WALK || state_q == ST_GET))
    else $error("memory read outside walk or get");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (in_accept || (state_q == ST_WALK && cnt_q == 6'd0)))
    else $error("memory write without a write beat or arming");

  a_get_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GET && k_q == 2'd2) |=> ##1 (state_q == ST_OUT))
    else $error("get sequence lost its output step");

endmodule

`default_nettype wire

// ===== hw/rtl/dsg_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-port-write, single-port-read byte store with a registered read.
module dsg_mem (
  input  wire logic              clk_i,
  input  wire dsg_pkg::mem_req_t req_i,
  output logic [7:0]             rdata_o
);
  import dsg_pkg::*;

  logic [7:0] mem_q [MemDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
